// ===== rtl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the TGA run-length decoder
// Field widths, reset values, register indexes, the sequencer state type and
// the structs that travel between the front, the queue and the back.
// ----------------------------------------------------------------------------
package trd_pkg;

   localparam int MAX_PIXEL_BYTES_DEF = 4;
   localparam int QUEUE_DEPTH_DEF     = 2;

   localparam int BYTE_W    = 8;
   localparam int PIXEL_W   = 32;
   localparam int REPEAT_W  = 8;
   localparam int BPP_W     = 3;
   localparam int TOTAL_W   = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 32;
   localparam int POS_W     = 2;

   localparam int RUN_FLAG_BIT = 7;

   localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PIXELS    = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXEL,
      PH_STOPPED
   } phase_type;

   // one input byte after classification
   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic                start_image;
      logic                is_run;
      logic [REPEAT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] wdata;
   } csr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      phase_type          phase;
      logic [TOTAL_W-1:0] total;
      logic [TOTAL_W-1:0] remaining;
      logic               last_fire;
   } back_status_type;

endpackage

// ===== rtl/trd_if.sv =====
// ----------------------------------------------------------------------------
// trd_if: valid/ready channels of the TGA run-length decoder
// Byte request channel and pixel response channel, each with a source and a
// sink modport.
// ----------------------------------------------------------------------------
interface trd_req_if;
   logic                       valid;
   logic                       ready;
   logic [trd_pkg::BYTE_W-1:0] data_byte;
   logic                       start_image;

   modport source (output valid, output data_byte, output start_image, input ready);
   modport sink   (input valid, input data_byte, input start_image, output ready);
endinterface

interface trd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [trd_pkg::PIXEL_W-1:0]  pixel_value;
   logic [trd_pkg::REPEAT_W-1:0] repeat_count;
   logic                         status;
   logic                         last;

   modport source (output valid, output pixel_value, output repeat_count,
                   output status, output last, input ready);
   modport sink   (input valid, input pixel_value, input repeat_count,
                   input status, input last, output ready);
endinterface

// ===== rtl/trd_front.sv =====
// ----------------------------------------------------------------------------
// trd_front: byte intake of the TGA run-length decoder
// Accepts one byte per cycle unless the queue stalls it, decodes the packet
// header fields it would carry and holds the classified byte for the queue.
// ----------------------------------------------------------------------------
module trd_front (
   input  logic               clock,
   input  logic               reset,
   trd_req_if.sink            req,
   output logic               out_valid,
   input  logic               out_ready,
   output trd_pkg::entry_type out_entry
);

   logic               valid_ff;
   logic               valid_in;
   trd_pkg::entry_type entry_ff;
   trd_pkg::entry_type entry_in;
   logic               take;

   assign req.ready = !valid_ff || out_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      entry_in             = entry_ff;
      valid_in             = valid_ff && !out_ready;
      if (take) begin
         valid_in             = 1'b1;
         entry_in.data_byte   = req.data_byte;
         entry_in.start_image = req.start_image;
         entry_in.is_run      = req.data_byte[trd_pkg::RUN_FLAG_BIT];
         entry_in.count       = {1'b0, req.data_byte[trd_pkg::RUN_FLAG_BIT-1:0]}
                                + trd_pkg::REPEAT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

// ===== rtl/trd_queue.sv =====
// ----------------------------------------------------------------------------
// trd_queue: classified-byte queue of the TGA run-length decoder
// Small FIFO that lets the intake and the decoding sequencer stall apart.
// DEPTH from 2 up.
// ----------------------------------------------------------------------------
module trd_queue #(
   parameter int DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  trd_pkg::entry_type        push_entry,
   output logic                      pop_valid,
   input  logic                      pop,
   output trd_pkg::entry_type        pop_entry,
   output trd_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   trd_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign status.full  = !push_ready;
   assign status.empty = !pop_valid;

endmodule

// ===== rtl/trd_back.sv =====
// ----------------------------------------------------------------------------
// trd_back: decoding sequencer of the TGA run-length decoder
// Holds the configuration registers and the packet state, gathers pixel
// bytes, counts pixels against the image total and drives the result register.
// ----------------------------------------------------------------------------
module trd_back #(
   parameter int MAX_PIXEL_BYTES = trd_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  trd_pkg::csr_type         csr,
   input  logic                     in_valid,
   output logic                     in_pop,
   input  trd_pkg::entry_type       in_entry,
   trd_rsp_if.source                rsp,
   output trd_pkg::back_status_type status
);

   localparam int GW = 8 * MAX_PIXEL_BYTES;
   localparam logic [trd_pkg::BPP_W-1:0] MAX_BYTES = trd_pkg::BPP_W'(MAX_PIXEL_BYTES);

   localparam int RW = trd_pkg::REPEAT_W;
   localparam int TW = trd_pkg::TOTAL_W;

   trd_pkg::phase_type           phase_ff, phase_in, eff_phase;
   logic [trd_pkg::BPP_W-1:0]    bpp_ff, bpp_in;
   logic [TW-1:0]                total_ff, total_in;
   logic                         is_run_ff, is_run_in;
   logic [RW-1:0]                left_ff, left_in;
   logic [trd_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [GW-1:0]                gather_ff, gather_in;
   logic [TW-1:0]                done_ff, done_in;
   logic [TW-1:0]                rem_ff, rem_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [trd_pkg::PIXEL_W-1:0]  value_ff, value_in;
   logic [RW-1:0]                rep_ff, rep_in;
   logic                         status_ff, status_in;
   logic                         last_ff, last_in;

   logic                         out_free, step, emit;
   logic [trd_pkg::BPP_W-1:0]    n_bytes;
   logic [TW-1:0]                eff_rem;
   logic                         hdr_overrun, pixel_end;
   logic [RW-1:0]                rep_raw, rep_clip, left_after;
   logic                         pix_st, pix_last;
   logic [GW-1:0]                gather_new;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign step     = in_valid && out_free;
   assign in_pop   = step;

   // start_image restarts the image before the byte is looked at
   assign eff_phase = in_entry.start_image ? trd_pkg::PH_HEADER : phase_ff;
   assign eff_rem   = in_entry.start_image ? total_ff : rem_ff;

   always_comb begin
      priority if (bpp_ff == '0) begin
         n_bytes = trd_pkg::BPP_W'(1);
      end else if (bpp_ff > MAX_BYTES) begin
         n_bytes = MAX_BYTES;
      end else begin
         n_bytes = bpp_ff;
      end
   end

   always_comb begin
      gather_new = gather_ff;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         if (pos_ff == trd_pkg::POS_W'(k)) begin
            gather_new[8*k +: 8] = in_entry.data_byte;
         end
      end
   end

   assign hdr_overrun = !in_entry.is_run && ({{(TW-RW){1'b0}}, in_entry.count} > eff_rem);
   assign pixel_end   = ({1'b0, pos_ff} + trd_pkg::BPP_W'(1)) >= n_bytes;
   assign rep_raw     = is_run_ff ? left_ff : RW'(1);
   assign pix_st      = {{(TW-RW){1'b0}}, rep_raw} > rem_ff;
   assign pix_last    = {{(TW-RW){1'b0}}, rep_raw} >= rem_ff;
   assign rep_clip    = pix_st ? rem_ff[RW-1:0] : rep_raw;
   assign left_after  = (is_run_ff || pix_st) ? '0 : left_ff - RW'(1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (eff_phase)
            trd_pkg::PH_HEADER: begin
               phase_in = hdr_overrun ? trd_pkg::PH_STOPPED : trd_pkg::PH_PIXEL;
            end
            trd_pkg::PH_PIXEL: begin
               priority if (!pixel_end) begin
                  phase_in = trd_pkg::PH_PIXEL;
               end else if (pix_last) begin
                  phase_in = trd_pkg::PH_STOPPED;
               end else if (left_after == '0) begin
                  phase_in = trd_pkg::PH_HEADER;
               end else begin
                  phase_in = trd_pkg::PH_PIXEL;
               end
            end
            default: begin
               phase_in = eff_phase;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      bpp_in    = bpp_ff;
      total_in  = total_ff;
      is_run_in = is_run_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      gather_in = gather_ff;
      done_in   = done_ff;
      rem_in    = rem_ff;
      value_in  = value_ff;
      rep_in    = rep_ff;
      status_in = status_ff;
      last_in   = last_ff;
      emit      = 1'b0;

      if (step) begin
         if (in_entry.start_image) begin
            done_in   = '0;
            rem_in    = total_ff;
            is_run_in = 1'b0;
            left_in   = '0;
            pos_in    = '0;
            gather_in = '0;
         end
         unique case (eff_phase)
            trd_pkg::PH_HEADER: begin
               is_run_in = in_entry.is_run;
               if (hdr_overrun) begin
                  left_in   = '0;
                  emit      = 1'b1;
                  value_in  = '0;
                  rep_in    = '0;
                  status_in = 1'b1;
                  last_in   = 1'b1;
               end else begin
                  left_in   = in_entry.count;
                  pos_in    = '0;
                  gather_in = '0;
               end
            end
            trd_pkg::PH_PIXEL: begin
               if (!pixel_end) begin
                  pos_in    = pos_ff + trd_pkg::POS_W'(1);
                  gather_in = gather_new;
               end else begin
                  pos_in    = '0;
                  gather_in = '0;
                  left_in   = left_after;
                  done_in   = done_ff + {{(TW-RW){1'b0}}, rep_clip};
                  rem_in    = rem_ff - {{(TW-RW){1'b0}}, rep_clip};
                  emit      = 1'b1;
                  value_in  = trd_pkg::PIXEL_W'(gather_new);
                  rep_in    = rep_clip;
                  status_in = pix_st;
                  last_in   = pix_last;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      if (csr.we) begin
         unique case (csr.index)
            trd_pkg::CSR_BYTES_PER_PIXEL: begin
               bpp_in = csr.wdata[trd_pkg::BPP_W-1:0];
            end
            trd_pkg::CSR_TOTAL_PIXELS: begin
               total_in = csr.wdata[TW-1:0];
               rem_in   = (done_ff >= csr.wdata[TW-1:0]) ? '0 : csr.wdata[TW-1:0] - done_ff;
            end
            default: begin
               bpp_in = bpp_ff;
            end
         endcase
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= trd_pkg::PH_HEADER;
         bpp_ff       <= trd_pkg::BPP_RESET;
         total_ff     <= trd_pkg::TOTAL_RESET;
         is_run_ff    <= 1'b0;
         left_ff      <= '0;
         pos_ff       <= '0;
         gather_ff    <= '0;
         done_ff      <= '0;
         rem_ff       <= trd_pkg::TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bpp_ff       <= bpp_in;
         total_ff     <= total_in;
         is_run_ff    <= is_run_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         gather_ff    <= gather_in;
         done_ff      <= done_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff  <= value_in;
      rep_ff    <= rep_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_value  = value_ff;
   assign rsp.repeat_count = rep_ff;
   assign rsp.status       = status_ff;
   assign rsp.last         = last_ff;

   assign status.phase     = phase_ff;
   assign status.total     = total_ff;
   assign status.remaining = rem_ff;
   assign status.last_fire = emit && last_in;

endmodule

// ===== rtl/tga_rle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tga_rle_decoder_core: TGA run-length pixel stream decoder
// Turns the compressed pixel stream of a TGA image, one byte per transaction,
// into pixel values with repeat counts, and flags completion and overruns.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                   handshake
//  req_bus   in         data_byte[7:0], start_image               valid/ready
//  rsp_bus   out        pixel_value[31:0], repeat_count[7:0],     valid/ready
//                       status, last
//  csr_*     in         csr_index[0], csr_wdata[31:0]             csr_we
//
//  Bytes are accepted and decoded one per cycle unless a stall reaches the
//  intake; the decoding sequencer retires one queued byte each cycle that
//  the result register is free. After its last byte is accepted, a result
//  passes through the intake register and the queue before the sequencer
//  loads the result register.
//  Reset is synchronous; it empties the pipeline, loads the register defaults
//  and makes the next byte a packet header.
//  A stalled response side fills the queue, then the intake register, then
//  drops req_bus.ready.
//
module tga_rle_decoder_core #(
   parameter int MAX_PIXEL_BYTES = trd_pkg::MAX_PIXEL_BYTES_DEF,
   parameter int QUEUE_DEPTH     = trd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   trd_req_if.sink                         req_bus,
   trd_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [trd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [trd_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   // intake -> queue
   logic                      front_valid;
   logic                      front_ready;
   trd_pkg::entry_type        front_entry;

   // queue -> sequencer
   logic                      queue_valid;
   logic                      queue_pop;
   trd_pkg::entry_type        queue_entry;
   trd_pkg::queue_status_type queue_status;

   trd_pkg::csr_type          csr;
   trd_pkg::back_status_type  back_status;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // classify each byte as it arrives
   trd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_entry (front_entry)
   );

   // decouple intake from decoding
   trd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_entry  (queue_entry),
      .status     (queue_status)
   );

   // decode packets, count pixels, drive the result register
   trd_back #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .in_valid (queue_valid),
      .in_pop   (queue_pop),
      .in_entry (queue_entry),
      .rsp      (rsp_bus),
      .status   (back_status)
   );

`ifndef SYNTHESIS
   // the remaining pixel count never exceeds the image total
   assert property (@(posedge clock) disable iff (reset)
      back_status.remaining <= back_status.total)
      else $error("remaining pixel count above image total");

   // a result that ends the image stops the decoder
   assert property (@(posedge clock) disable iff (reset)
      back_status.last_fire |=> (back_status.phase == trd_pkg::PH_STOPPED))
      else $error("decoder not stopped after last result");

   // the queue cannot be full and empty at once
   assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue reports full and empty");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tga_rle_decoder_core
// Feeds compressed TGA byte streams through the request channel, decodes
// every accepted byte in a local copy of the decoder state and compares each
// response transaction field by field with the oldest predicted pixel.
// Directed tests cover reset defaults, pixel sizes and overruns; a random
// test then runs well-formed images with broken restarts and noise mixed in.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 600;
   localparam logic [trd_pkg::TOTAL_W-1:0] TOTAL_MAX = 32'd4294836225;

   // one decoded pixel as it leaves on the response channel
   typedef struct packed {
      logic [trd_pkg::PIXEL_W-1:0]  value;
      logic [trd_pkg::REPEAT_W-1:0] rep;
      logic                         status;
      logic                         last;
   } pixel_result_type;

   logic clock;
   logic reset;
   logic                          csr_we;
   logic [trd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [trd_pkg::CSR_DAT_W-1:0] csr_wdata;

   trd_req_if req_bus ();
   trd_rsp_if rsp_bus ();

   tga_rle_decoder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Decoder state mirror: updated once per accepted request transaction
   // ------------------------------------------------------------------------
   trd_pkg::phase_type           seq_phase;
   logic                         pkt_run;
   logic [trd_pkg::REPEAT_W-1:0] pkt_left;
   logic [trd_pkg::POS_W-1:0]    byte_idx;
   logic [trd_pkg::PIXEL_W-1:0]  px_acc;
   logic [trd_pkg::TOTAL_W-1:0]  px_emitted;
   logic [trd_pkg::BPP_W-1:0]    cfg_bpp;
   logic [trd_pkg::TOTAL_W-1:0]  cfg_total;

   pixel_result_type expected_pixels[$];
   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;

   // Clamp the configured pixel size: zero counts as one byte, anything above
   // the widest pixel counts as the widest pixel.
   function automatic int pixel_size();
      int n;
      n = int'(cfg_bpp);
      if (n == 0) n = 1;
      if (n > trd_pkg::MAX_PIXEL_BYTES_DEF) n = trd_pkg::MAX_PIXEL_BYTES_DEF;
      return n;
   endfunction

   function automatic logic [trd_pkg::TOTAL_W-1:0] pixels_remaining();
      return (px_emitted >= cfg_total) ? '0 : cfg_total - px_emitted;
   endfunction

   // Advance the mirror by one byte; return 1 when the byte yields a pixel.
   function automatic bit decode_tga_byte(input logic [trd_pkg::BYTE_W-1:0] b,
                                          input logic s,
                                          output pixel_result_type r);
      logic [trd_pkg::REPEAT_W-1:0] count;
      logic [trd_pkg::TOTAL_W-1:0]  rem;
      r = '0;
      // start of image clears everything before the byte is looked at
      if (s) begin
         seq_phase  = trd_pkg::PH_HEADER;
         pkt_run    = 1'b0;
         pkt_left   = '0;
         byte_idx   = '0;
         px_acc     = '0;
         px_emitted = '0;
      end
      if (seq_phase == trd_pkg::PH_HEADER) begin
         count   = {1'b0, b[6:0]} + 8'd1;
         pkt_run = b[trd_pkg::RUN_FLAG_BIT];
         // raw packet that cannot fit: report at the header and stop
         if (!pkt_run && count > pixels_remaining()) begin
            seq_phase = trd_pkg::PH_STOPPED;
            pkt_left  = '0;
            r.status  = 1'b1;
            r.last    = 1'b1;
            return 1'b1;
         end
         pkt_left  = count;
         byte_idx  = '0;
         px_acc    = '0;
         seq_phase = trd_pkg::PH_PIXEL;
         return 1'b0;
      end
      if (seq_phase != trd_pkg::PH_PIXEL) return 1'b0;

      // gather little-endian pixel bytes
      px_acc |= {24'd0, b} << (8 * byte_idx);
      if (int'(byte_idx) + 1 < pixel_size()) begin
         byte_idx++;
         return 1'b0;
      end

      rem      = pixels_remaining();
      r.value  = px_acc;
      byte_idx = '0;
      px_acc   = '0;
      if (pkt_run) begin
         // clip an overlong run to what is left of the image
         if (trd_pkg::TOTAL_W'(pkt_left) > rem) begin
            r.rep    = rem[trd_pkg::REPEAT_W-1:0];
            r.status = 1'b1;
         end else begin
            r.rep = pkt_left;
         end
         pkt_left = '0;
      end else if (rem == '0) begin
         r.rep    = '0;
         r.status = 1'b1;
         pkt_left = '0;
      end else begin
         r.rep    = 8'd1;
         pkt_left = pkt_left - 8'd1;
      end
      px_emitted = px_emitted + trd_pkg::TOTAL_W'(r.rep);
      r.last     = r.status || (px_emitted >= cfg_total);
      if (r.last) seq_phase = trd_pkg::PH_STOPPED;
      else if (pkt_left == '0) seq_phase = trd_pkg::PH_HEADER;
      else seq_phase = trd_pkg::PH_PIXEL;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Response side: stall on a pattern that is picked anew after a random span.
   // Modes: always ready, coin toss, repeating 8-bit mask, long stalls.
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int         mode;
      int         span;
      int         k;
      logic [7:0] mask;
      mode = 0;
      span = 0;
      k    = 0;
      mask = '0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            mask = 8'($urandom);
         end
         span--;
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= mask[k % 8];
            default: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
         endcase
         k++;
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: compare each accepted pixel with the oldest prediction
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_pixels
      pixel_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel: expected none, actual value %h rep %0d st %b last %b",
                     $time, rsp_bus.pixel_value, rsp_bus.repeat_count, rsp_bus.status,
                     rsp_bus.last);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_value", want.value, rsp_bus.pixel_value);
            check_field("repeat_count", 32'(want.rep), 32'(rsp_bus.repeat_count));
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("last", 32'(want.last), 32'(rsp_bus.last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Send one byte transaction. The sender works in bursts; between bursts it
   // drops valid for a random gap (sometimes none, so bursts run together).
   task automatic send_byte(input logic [trd_pkg::BYTE_W-1:0] b, input logic s);
      pixel_result_type r;
      int               gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.start_image <= s;
      // hold until the transaction is taken
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (decode_tga_byte(b, s, r)) expected_pixels.push_back(r);
   endtask

   // Hold the sender off until every predicted pixel has come back, then give
   // header bytes still inside the pipeline time to retire.
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write; call only while the decoder is idle.
   task automatic csr_write(input logic [trd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [trd_pkg::CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == trd_pkg::CSR_BYTES_PER_PIXEL) cfg_bpp = data[trd_pkg::BPP_W-1:0];
      else cfg_total = data;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset defaults: 3-byte pixels, one-pixel image; first byte is a header
   // without start_image, and bytes after completion are dropped.
   task automatic test_after_reset();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h12, 1'b0);
   endtask

   // Out-of-range pixel sizes: zero acts as one byte, seven as four bytes.
   task automatic test_pixel_sizes();
      wait_results_drained();
      csr_write(trd_pkg::CSR_BYTES_PER_PIXEL, 32'd0);
      csr_write(trd_pkg::CSR_TOTAL_PIXELS, TOTAL_MAX);
      send_byte(8'h81, 1'b1);
      send_byte(8'hFF, 1'b0);
      wait_results_drained();
      csr_write(trd_pkg::CSR_BYTES_PER_PIXEL, 32'd7);
      // raw packet of two full-width pixels, all ones then all zeros
      send_byte(8'h01, 1'b0);
      repeat (4) send_byte(8'hFF, 1'b0);
      repeat (4) send_byte(8'h00, 1'b0);
   endtask

   // Raw overrun at the header, clipped run, total lowered below the pixels
   // already emitted (run clipped to zero), and a zero total.
   task automatic test_overruns();
      wait_results_drained();
      csr_write(trd_pkg::CSR_BYTES_PER_PIXEL, 32'd1);
      csr_write(trd_pkg::CSR_TOTAL_PIXELS, 32'd3);
      send_byte(8'h03, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hC3, 1'b0);
      wait_results_drained();
      csr_write(trd_pkg::CSR_TOTAL_PIXELS, 32'd0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // Random images: each round drains, picks new settings and sends a stream
   // shaped by the mirrored decoder phase. Most bytes form well-formed
   // packets; a few restart mid-packet, and noise is sent while stopped.
   task automatic test_random_streams();
      int                         sent;
      int                         j;
      int                         round_len;
      int                         pick;
      logic [trd_pkg::BYTE_W-1:0] b;
      logic                       s;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_results_drained();
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            csr_write(trd_pkg::CSR_BYTES_PER_PIXEL, 32'((pick % 4) + 1));
         end else if (pick == 8) begin
            csr_write(trd_pkg::CSR_BYTES_PER_PIXEL, 32'd0);
         end else begin
            csr_write(trd_pkg::CSR_BYTES_PER_PIXEL, 32'($urandom_range(5, 7)));
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            csr_write(trd_pkg::CSR_TOTAL_PIXELS, 32'd0);
         end else if (pick < 3) begin
            csr_write(trd_pkg::CSR_TOTAL_PIXELS, $urandom_range(1000, TOTAL_MAX));
         end else if (pick < 6) begin
            csr_write(trd_pkg::CSR_TOTAL_PIXELS, $urandom_range(129, 600));
         end else begin
            csr_write(trd_pkg::CSR_TOTAL_PIXELS, $urandom_range(1, 128));
         end

         round_len = $urandom_range(20, 100);
         j = 0;
         while (j < round_len) begin
            b = trd_pkg::BYTE_W'($urandom);
            case (seq_phase)
               trd_pkg::PH_STOPPED: s = ($urandom_range(0, 7) != 0);
               trd_pkg::PH_HEADER: begin
                  s = ($urandom_range(0, 39) == 0);
                  // favor short packets so images finish within a round
                  if ($urandom_range(0, 1) != 0) b[6:0] = 7'($urandom_range(0, 7));
               end
               default: s = ($urandom_range(0, 63) == 0);
            endcase
            // bytes dropped by a stopped decoder do not count
            if (seq_phase != trd_pkg::PH_STOPPED || s) begin
               j++;
               sent++;
            end
            send_byte(b, s);
            if ($urandom_range(0, 199) == 0) wait_results_drained();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.start_image <= 1'b0;
      seq_phase  = trd_pkg::PH_HEADER;
      pkt_run    = 1'b0;
      pkt_left   = '0;
      byte_idx   = '0;
      px_acc     = '0;
      px_emitted = '0;
      cfg_bpp    = trd_pkg::BPP_RESET;
      cfg_total  = trd_pkg::TOTAL_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_pixel_sizes();
      test_overruns();
      test_random_streams();

      wait_results_drained();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
